### design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the block bitmap allocator: request codes,
// status codes, register indexes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package bba_pkg;

    // field widths of the channels
    localparam int REQ_W     = 3;
    localparam int IDX_W     = 12;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int BMC_W     = 4;
    localparam int CNT_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // request codes
    localparam t_req REQ_ALLOC_DATA  = 3'd0;
    localparam t_req REQ_FREE_DATA   = 3'd1;
    localparam t_req REQ_FIND_INODE  = 3'd2;
    localparam t_req REQ_MARK_USED   = 3'd3;
    localparam t_req REQ_MARK_UNUSED = 3'd4;
    localparam t_req REQ_LOAD_WORD   = 3'd5;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // register indexes
    localparam t_cfg_idx CFG_BITMAP_COUNT = 2'd0;
    localparam t_cfg_idx CFG_INODE_COUNT  = 2'd1;
    localparam t_cfg_idx CFG_DATA_COUNT   = 2'd2;

    localparam logic [BMC_W-1:0] BITMAP_COUNT_RST = 4'd1;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_FOUND,
        S_MODIFY,
        S_DONE
    } t_state;

endpackage

### design/block_bitmap_allocator_unit.sv
// From acceptance, a load or a rejected request goes straight to the result state;
// free/mark pass the word locate and a read-modify-write state; alloc/find pass the
// word locate, the scan and, when a free bit is found, a found state. A reciprocal
// multiply and then a remainder step locate the start word; the scan reads one word
// per cycle. One request at a time: the next is taken in the cycle after the result
// is loaded. After reset a clearing pass writes zero to all MAP_DEPTH words.
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit used-map allocator for the data and inode regions of a disk,
// one bit per block, with an iterative word locate and word-serial scan.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int TOTAL_BLOCKS  = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [WORD_W-1:0]    i_load_word,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [IDX_W-1:0]     o_found_index
);

    localparam int MAP_DEPTH = (TOTAL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int TB_W      = $clog2(TOTAL_BLOCKS + 1);
    localparam int SUM_W     = ((TB_W > 14) ? TB_W : 14) + 1;
    // reciprocal of the word size, exact for every SUM_W-bit dividend
    localparam int RECIP_SH  = SUM_W + BIT_W;
    localparam int PROD_W    = SUM_W + RECIP_SH + 1;
    localparam logic [RECIP_SH:0] RECIP_M = (RECIP_SH + 1)'(
        ((64'd1 << RECIP_SH) + 64'(MAP_WORD_BITS) - 64'd1) / 64'(MAP_WORD_BITS));
    localparam logic [SUM_W-1:0]  TOTAL_S   = SUM_W'(TOTAL_BLOCKS);
    localparam logic [SUM_W-1:0]  WB_S      = SUM_W'(MAP_WORD_BITS);
    localparam logic [IDX_W:0]    DEPTH_I   = (IDX_W + 1)'(MAP_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

    // state and registers
    t_state r_state, n_state;
    logic [BMC_W-1:0]         r_bmc;
    logic [CNT_W-1:0]         r_ibc, r_dbc;
    t_req                     r_req, n_req;
    logic [SUM_W-1:0]         r_target, n_target;
    logic [SUM_W-1:0]         r_end, n_end;
    logic [ADDR_W-1:0]        r_quot, n_quot;
    logic                     r_step, n_step;
    logic [ADDR_W-1:0]        r_word, n_word;
    logic [SUM_W-1:0]         r_wpos, n_wpos;
    logic [BIT_W-1:0]         r_lo, n_lo;
    logic [BIT_W-1:0]         r_bit, n_bit;
    t_status                  r_status, n_status;
    logic [IDX_W-1:0]         r_found, n_found;
    logic [ADDR_W-1:0]        r_clr, n_clr;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic [IDX_W-1:0]         r_out_found, n_out_found;

    // memory port signals
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [MAP_WORD_BITS-1:0] ram_wr_data;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [MAP_WORD_BITS-1:0] ram_rd_data;

    // request decode
    logic                     in_acc;
    logic [SUM_W-1:0]         ibase, dbase, base, rend, dividend;
    logic [CNT_W-1:0]         count;
    logic                     is_scan, past_map, idx_bad;

    // start word locate
    logic [PROD_W-1:0]        prod;
    logic [ADDR_W-1:0]        quot_calc;
    logic [SUM_W-1:0]         word_base, word_off;

    // scan word check
    logic [SUM_W-1:0]         remaining;
    logic [MAP_WORD_BITS-1:0] mask, free_bits;
    logic                     any_free;
    logic [BIT_W-1:0]         free_pos;
    logic [SUM_W-1:0]         rel;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // region bases and bounds
    assign ibase    = SUM_W'(r_bmc) + SUM_W'(1);
    assign dbase    = ibase + SUM_W'(r_ibc);
    assign base     = (i_req_type <= REQ_FREE_DATA) ? dbase : ibase;
    assign count    = (i_req_type <= REQ_FREE_DATA) ? r_dbc : r_ibc;
    assign rend     = base + SUM_W'(count);
    assign past_map = (rend > TOTAL_S);
    assign is_scan  = (i_req_type == REQ_ALLOC_DATA) || (i_req_type == REQ_FIND_INODE);
    assign idx_bad  = (i_block_index >= count);
    assign dividend = is_scan ? base : base + SUM_W'(i_block_index);

    // word index by reciprocal multiply, then word start and bit offset
    assign prod      = PROD_W'(r_target) * PROD_W'(RECIP_M);
    assign quot_calc = prod[RECIP_SH +: ADDR_W];
    assign word_base = SUM_W'(r_quot) * WB_S;
    assign word_off  = r_target - word_base;

    // in-range free bits of the current word and lowest free position
    assign remaining = r_end - r_wpos;
    always_comb begin
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            mask[i] = (BIT_W'(i) >= r_lo) && (SUM_W'(i) < remaining);
        end
        free_bits = ~ram_rd_data & mask;
        any_free  = |free_bits;
        free_pos  = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_pos = BIT_W'(i);
            end
        end
    end

    assign rel = r_wpos + SUM_W'(r_bit) - r_target;

    // sequencer next state and memory control
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_target     = r_target;
        n_end        = r_end;
        n_quot       = r_quot;
        n_step       = r_step;
        n_word       = r_word;
        n_wpos       = r_wpos;
        n_lo         = r_lo;
        n_bit        = r_bit;
        n_status     = r_status;
        n_found      = r_found;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_word;
        ram_wr_data  = '0;
        ram_rd_addr  = r_word;

        case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr;
                n_clr       = r_clr + ADDR_W'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_req   = i_req_type;
                    n_found = '0;
                    n_state = S_DONE;
                    if (i_req_type == REQ_LOAD_WORD) begin
                        if ({1'b0, i_block_index} < DEPTH_I) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = i_block_index[ADDR_W-1:0];
                            ram_wr_data = MAP_WORD_BITS'(i_load_word);
                            n_status    = ST_OK;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end else if (i_req_type > REQ_MARK_UNUSED || past_map) begin
                        n_status = ST_RANGE;
                    end else if (is_scan && count == '0) begin
                        n_status = ST_FULL;
                    end else if (!is_scan && idx_bad) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_target = dividend;
                        n_end    = rend;
                        n_step   = 1'b0;
                        n_state  = S_DIV;
                    end
                end
            end

            S_DIV: begin
                if (!r_step) begin
                    n_quot = quot_calc;
                    n_step = 1'b1;
                end else begin
                    n_word      = r_quot;
                    n_lo        = word_off[BIT_W-1:0];
                    n_wpos      = word_base;
                    ram_rd_addr = r_quot;
                    if (r_req == REQ_ALLOC_DATA || r_req == REQ_FIND_INODE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_MODIFY;
                    end
                end
            end

            S_SCAN: begin
                if (any_free) begin
                    n_bit = free_pos;
                    if (r_req == REQ_ALLOC_DATA) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | (MAP_WORD_BITS'(1) << free_pos);
                    end
                    n_state = S_FOUND;
                end else if (remaining <= WB_S) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_word      = r_word + ADDR_W'(1);
                    ram_rd_addr = r_word + ADDR_W'(1);
                    n_wpos      = r_wpos + WB_S;
                    n_lo        = '0;
                end
            end

            S_FOUND: begin
                n_found  = rel[IDX_W-1:0];
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            S_MODIFY: begin
                ram_wr_en = 1'b1;
                if (r_req == REQ_MARK_USED) begin
                    ram_wr_data = ram_rd_data | (MAP_WORD_BITS'(1) << r_lo);
                end else begin
                    ram_wr_data = ram_rd_data & ~(MAP_WORD_BITS'(1) << r_lo);
                end
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bmc <= BITMAP_COUNT_RST;
            r_ibc <= '0;
            r_dbc <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BITMAP_COUNT: r_bmc <= i_cfg_data[BMC_W-1:0];
                CFG_INODE_COUNT:  r_ibc <= i_cfg_data[CNT_W-1:0];
                CFG_DATA_COUNT:   r_dbc <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_target     <= n_target;
        r_end        <= n_end;
        r_quot       <= n_quot;
        r_step       <= n_step;
        r_word       <= n_word;
        r_wpos       <= n_wpos;
        r_lo         <= n_lo;
        r_bit        <= n_bit;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_found;

    // used map storage
    bba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

### design/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator: result hold, result coding,
// one transaction in flight and the clearing pass after reset.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [IDX_W-1:0]    o_found_index
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_found_index))
        else $error("stalled result changed");

    // failed requests report index zero
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_found_index == '0)
        else $error("nonzero index with failing status");

    // only one transaction in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while busy");

    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("request accepted during clearing pass");

endmodule

bind block_bitmap_allocator_unit bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_found_index (o_found_index)
);
